// ===== sv/i2cm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam int unsigned SlotWidth  = 16;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CountWidth = 4;
   localparam int unsigned CmdWidth   = 3;

   localparam logic [SlotWidth-1:0]  SLOT_RESET    = 16'd60;
   localparam logic [CountWidth-1:0] BITS_PER_BYTE = 4'd8;

   typedef enum logic [CmdWidth-1:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_START_A = 4'd1,
      PH_START_B = 4'd2,
      PH_STOP_A  = 4'd3,
      PH_STOP_B  = 4'd4,
      PH_WR_HIGH = 4'd5,
      PH_WR_LOW  = 4'd6,
      PH_WR_ACK  = 4'd7,
      PH_RD_HIGH = 4'd8,
      PH_RD_LOW  = 4'd9,
      PH_RD_ACK  = 4'd10
   } phase_type;

   typedef struct packed {
      phase_type              phase;
      logic [CountWidth-1:0]  bit_count;
      logic [ByteWidth-1:0]   shift_reg;
      logic [SlotWidth-1:0]   slot_counter;
      logic                   ack_to_send;
      logic                   ack_flag;
      logic                   scl_level;
      logic                   sda_level;
      logic [ByteWidth-1:0]   read_byte;
   } engine_state_type;

   typedef struct packed {
      logic [CmdWidth-1:0]  command;
      logic [ByteWidth-1:0] write_byte;
      logic                 send_ack;
      logic                 sda_line;
   } request_type;

   localparam engine_state_type STATE_RESET = '{
      phase:        PH_IDLE,
      bit_count:    '0,
      shift_reg:    '0,
      slot_counter: '0,
      ack_to_send:  1'b0,
      ack_flag:     1'b0,
      scl_level:    1'b1,
      sda_level:    1'b1,
      read_byte:    '0
   };

endpackage : i2cm_pkg
`default_nettype wire

// ===== sv/i2cm_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus phase sequencer: next engine state for one bus tick.
// ----------------------------------------------------------------------------
module i2cm_seq
   import i2cm_pkg::*;
(
   input  var engine_state_type          state_cur,
   input  var request_type               req,
   input  var logic [SlotWidth-1:0]      slot_limit,
   output engine_state_type              state_nxt,
   output logic                          done
);

   logic [CountWidth-1:0] count_inc;
   logic [ByteWidth-1:0]  shift_up;

   assign count_inc = state_cur.bit_count + 1'b1;
   assign shift_up  = {state_cur.shift_reg[ByteWidth-2:0], 1'b0};

   always_comb begin
      state_nxt = state_cur;
      done      = 1'b0;
      if (state_cur.phase == PH_IDLE) begin
         state_nxt.slot_counter = 16'd1;
         case (req.command)
            CMD_START: begin
               state_nxt.phase     = PH_START_A;
               state_nxt.sda_level = 1'b1;
               state_nxt.scl_level = 1'b1;
            end
            CMD_STOP: begin
               state_nxt.phase     = PH_STOP_A;
               state_nxt.sda_level = 1'b0;
               state_nxt.scl_level = 1'b1;
            end
            CMD_WRITE: begin
               state_nxt.phase     = PH_WR_HIGH;
               state_nxt.shift_reg = req.write_byte;
               state_nxt.bit_count = '0;
               state_nxt.sda_level = req.write_byte[ByteWidth-1];
               state_nxt.scl_level = 1'b1;
            end
            CMD_READ: begin
               state_nxt.phase       = PH_RD_HIGH;
               state_nxt.shift_reg   = '0;
               state_nxt.bit_count   = '0;
               state_nxt.ack_to_send = req.send_ack;
               state_nxt.sda_level   = 1'b1;
               state_nxt.scl_level   = 1'b1;
            end
            default: begin
               // no command: stay idle
               state_nxt.slot_counter = state_cur.slot_counter;
            end
         endcase
      end else if (state_cur.slot_counter >= slot_limit) begin
         // slot over: move on, most branches open a fresh slot
         state_nxt.slot_counter = 16'd1;
         case (state_cur.phase)
            PH_START_A: begin
               state_nxt.sda_level = 1'b0;
               state_nxt.phase     = PH_START_B;
            end
            PH_START_B: begin
               state_nxt.scl_level = 1'b0;
               done                = 1'b1;
            end
            PH_STOP_A: begin
               state_nxt.sda_level = 1'b1;
               state_nxt.phase     = PH_STOP_B;
            end
            PH_STOP_B: begin
               done = 1'b1;
            end
            PH_WR_HIGH: begin
               state_nxt.scl_level = 1'b0;
               state_nxt.phase     = PH_WR_LOW;
            end
            PH_WR_LOW: begin
               state_nxt.shift_reg = shift_up;
               state_nxt.bit_count = count_inc;
               state_nxt.scl_level = 1'b1;
               if (count_inc >= BITS_PER_BYTE) begin
                  state_nxt.sda_level = 1'b1;
                  state_nxt.phase     = PH_WR_ACK;
               end else begin
                  state_nxt.sda_level = shift_up[ByteWidth-1];
                  state_nxt.phase     = PH_WR_HIGH;
               end
            end
            PH_WR_ACK: begin
               state_nxt.ack_flag  = ~req.sda_line;
               state_nxt.scl_level = 1'b0;
               done                = 1'b1;
            end
            PH_RD_HIGH: begin
               state_nxt.shift_reg = {state_cur.shift_reg[ByteWidth-2:0], req.sda_line};
               state_nxt.scl_level = 1'b0;
               state_nxt.phase     = PH_RD_LOW;
            end
            PH_RD_LOW: begin
               state_nxt.bit_count = count_inc;
               state_nxt.scl_level = 1'b1;
               if (count_inc >= BITS_PER_BYTE) begin
                  state_nxt.sda_level = ~state_cur.ack_to_send;
                  state_nxt.phase     = PH_RD_ACK;
               end else begin
                  state_nxt.phase     = PH_RD_HIGH;
               end
            end
            PH_RD_ACK: begin
               state_nxt.scl_level = 1'b0;
               state_nxt.sda_level = 1'b1;
               state_nxt.read_byte = state_cur.shift_reg;
               done                = 1'b1;
            end
            default: begin
               // undefined phase: back to idle, pins untouched
               done = 1'b1;
            end
         endcase
         if (done) begin
            state_nxt.phase        = PH_IDLE;
            state_nxt.slot_counter = '0;
         end
      end else begin
         state_nxt.slot_counter = state_cur.slot_counter + 1'b1;
      end
   end

endmodule : i2cm_seq
`default_nettype wire

// ===== sv/i2c_master_byte_engine_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_unit
// I2C master byte engine: start, stop, byte write and byte read sequences.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+----------------------------------------
//  req     | req_valid / req_ready    | command, write_byte, send_ack, sda_line
//  rsp     | rsp_valid / rsp_ready    | scl/sda drive, busy, done, read_data, ack
//  csr     | csr_wr_en (no wait)      | csr_wr_data = ticks_per_slot
//
//  One request is one bus tick; the sequencer updates its state and the
//  response register in the cycle the request is accepted, so the response is
//  valid in the next cycle; one request is taken per cycle unless a full response register is not drained.
//  req_ready is high whenever the response register is empty or being drained.
//  Synchronous reset puts the engine idle with both pins released.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_unit
   import i2cm_pkg::*;
(
   input  var logic                 clock,
   input  var logic                 reset,
   input  var logic                 req_valid,
   output logic                     req_ready,
   input  var logic [CmdWidth-1:0]  req_command,
   input  var logic [ByteWidth-1:0] req_write_byte,
   input  var logic                 req_send_ack,
   input  var logic                 req_sda_line,
   output logic                     rsp_valid,
   input  var logic                 rsp_ready,
   output logic                     rsp_scl_drive,
   output logic                     rsp_sda_drive,
   output logic                     rsp_busy_res,
   output logic                     rsp_done_res,
   output logic [ByteWidth-1:0]     rsp_read_data,
   output logic                     rsp_ack_seen,
   input  var logic                 csr_wr_en,
   input  var logic [SlotWidth-1:0] csr_wr_data
);

   engine_state_type     state_ff, state_in;
   request_type          req;
   logic [SlotWidth-1:0] slot_len_ff, slot_limit;
   logic                 rsp_valid_ff;
   logic                 done_in, accept;
   logic                 scl_ff, sda_ff, busy_ff, done_ff, ack_ff;
   logic [ByteWidth-1:0] rdata_ff;

   assign req        = '{command: req_command, write_byte: req_write_byte,
                         send_ack: req_send_ack, sda_line: req_sda_line};
   assign slot_limit = (slot_len_ff == '0) ? 16'd1 : slot_len_ff;
   assign req_ready  = ~rsp_valid_ff | rsp_ready;
   assign accept     = req_valid & req_ready;

   i2cm_seq u_seq (
      .state_cur  (state_ff),
      .req        (req),
      .slot_limit (slot_limit),
      .state_nxt  (state_in),
      .done       (done_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_len_ff <= SLOT_RESET;
      end else if (csr_wr_en) begin
         slot_len_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         scl_ff   <= state_in.scl_level;
         sda_ff   <= state_in.sda_level;
         busy_ff  <= (state_in.phase != PH_IDLE);
         done_ff  <= done_in;
         rdata_ff <= state_in.read_byte;
         ack_ff   <= state_in.ack_flag;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_drive = scl_ff;
   assign rsp_sda_drive = sda_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_done_res  = done_ff;
   assign rsp_read_data = rdata_ff;
   assign rsp_ack_seen  = ack_ff;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done reported while still busy");

   a_slot_running: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase != PH_IDLE |-> state_ff.slot_counter != '0)
      else $error("active slot with zero counter");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.bit_count <= BITS_PER_BYTE)
      else $error("bit counter past one byte");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(state_ff))
      else $error("engine state moved without a request");

   a_start_drives_high: assert property (@(posedge clock) disable iff (reset)
      accept && state_ff.phase == PH_IDLE && req_command == CMD_START
      |=> rsp_scl_drive && rsp_sda_drive && rsp_busy_res)
      else $error("start did not release both lines");

endmodule : i2c_master_byte_engine_unit
`default_nettype wire
